// ----- hw/rtl/at_response_rx_framer_core_assert.svh -----
// Assertion macros shared by the receive framer RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef AT_RESPONSE_RX_FRAMER_CORE_ASSERT_SVH
`define AT_RESPONSE_RX_FRAMER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ATRF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ATRF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/atrf_pkg.sv -----
// Shared types and constants of the receive framer.
// No dependencies; used by every module of the block.
package atrf_pkg;

    localparam int BYTE_W  = 8;
    localparam int IDX_W   = 9;
    localparam int QUIET_W = 16;

    localparam logic [QUIET_W-1:0] QUIET_RELOAD_RESET = 16'd5;

    // Last valid write index of each buffer; the index wraps after it.
    localparam logic [IDX_W-1:0] ANS_BUF_SIZE = 9'd256;
    localparam logic [IDX_W-1:0] PKT_BUF_SIZE = 9'd256;

    localparam logic [BYTE_W-1:0] CH_A    = 8'h41;
    localparam logic [BYTE_W-1:0] CH_R    = 8'h52;
    localparam logic [BYTE_W-1:0] CH_S    = 8'h53;
    localparam logic [BYTE_W-1:0] CH_0    = 8'h30;
    localparam logic [BYTE_W-1:0] CH_4    = 8'h34;
    localparam logic [BYTE_W-1:0] CH_PLUS = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_LF   = 8'h0A;

    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    localparam logic TGT_ANSWER = 1'b0;
    localparam logic TGT_PACKET = 1'b1;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    // Classified item passed from the front to the back.
    typedef struct packed {
        logic              is_tick;
        logic [BYTE_W-1:0] data;
        logic              opens_answer;
        logic              opens_packet;
        logic              is_newline;
    } cmd_t;

    // Result item held in the output register.
    typedef struct packed {
        logic              wr_en;
        logic              wr_target;
        logic [IDX_W-1:0]  wr_addr;
        logic [BYTE_W-1:0] wr_data;
        logic              answer_ready;
        logic              packet_ready;
        logic              answer_overflow;
        logic              packet_overflow;
    } result_t;

endpackage

// ----- hw/rtl/atrf_front.sv -----
// Input side of the receive framer: takes items and classifies each byte.
// Depends on atrf_pkg; feeds atrf_queue.
module atrf_front
(
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [atrf_pkg::BYTE_W-1:0] s_axis_tdata,  // [7:0] rx_byte
    input  logic                      s_axis_tuser,  // [0] action
    output logic                      push_valid,
    input  logic                      push_ready,
    output atrf_pkg::cmd_t            push_cmd
);

    logic [atrf_pkg::BYTE_W-1:0] b;

    assign b = s_axis_tdata;

    always_comb
    begin
        push_cmd.is_tick      = (s_axis_tuser == atrf_pkg::ACT_TICK);
        push_cmd.data         = b;
        push_cmd.opens_answer = (b == atrf_pkg::CH_A) || (b == atrf_pkg::CH_R)
                                || (b == atrf_pkg::CH_S);
        push_cmd.opens_packet = ((b >= atrf_pkg::CH_0) && (b <= atrf_pkg::CH_4))
                                || (b == atrf_pkg::CH_PLUS);
        push_cmd.is_newline   = (b == atrf_pkg::CH_LF);
    end

    assign push_valid    = s_axis_tvalid;
    assign s_axis_tready = push_ready;

endmodule

// ----- hw/rtl/atrf_queue.sv -----
// Two-entry queue of classified items between the front and the back.
// Depends on atrf_pkg.
module atrf_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  atrf_pkg::cmd_t push_cmd,
    output logic           pop_valid,
    input  logic           pop_ready,
    output atrf_pkg::cmd_t pop_cmd
);

    atrf_pkg::cmd_t                  slot_reg [atrf_pkg::Q_DEPTH];
    logic [atrf_pkg::Q_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [atrf_pkg::Q_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [atrf_pkg::Q_CNT_W-1:0]    count_reg, count_next;
    logic                            do_push;
    logic                            do_pop;

    assign push_ready = (count_reg != atrf_pkg::Q_CNT_W'(atrf_pkg::Q_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- hw/rtl/atrf_back.sv -----
// Frame state, quiet counter and output register of the receive framer.
// Depends on atrf_pkg and the assertion macro header.
`include "at_response_rx_framer_core_assert.svh"

module atrf_back
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [atrf_pkg::QUIET_W-1:0] cfg_data,
    input  logic                         pop_valid,
    output logic                         pop_ready,
    input  atrf_pkg::cmd_t               pop_cmd,
    output logic                         out_valid,
    input  logic                         out_ready,
    output atrf_pkg::result_t            out_result
);

    logic [atrf_pkg::QUIET_W-1:0] quiet_reload_reg, quiet_reload_next;
    logic [atrf_pkg::QUIET_W-1:0] quiet_count_reg, quiet_count_next;
    logic [atrf_pkg::QUIET_W-1:0] quiet_dec;
    logic [atrf_pkg::IDX_W-1:0]   write_index_reg, write_index_next;
    logic                         answer_open_reg, answer_open_next;
    logic                         answer_line_end_reg, answer_line_end_next;
    logic                         packet_open_reg, packet_open_next;
    logic                         packet_line_end_reg, packet_line_end_next;
    logic                         out_valid_reg, out_valid_next;
    atrf_pkg::result_t            result_reg, result_next;
    logic                         step;

    assign cfg_ready  = 1'b1;
    assign pop_ready  = !out_valid_reg || out_ready;
    assign step       = pop_valid && pop_ready;
    assign out_valid  = out_valid_reg;
    assign out_result = result_reg;
    assign quiet_dec  = (quiet_count_reg != '0) ? quiet_count_reg - 1'b1 : '0;

    always_comb
    begin
        quiet_reload_next    = (cfg_valid && cfg_ready) ? cfg_data : quiet_reload_reg;
        quiet_count_next     = quiet_count_reg;
        write_index_next     = write_index_reg;
        answer_open_next     = answer_open_reg;
        answer_line_end_next = answer_line_end_reg;
        packet_open_next     = packet_open_reg;
        packet_line_end_next = packet_line_end_reg;
        result_next          = '0;

        if (!pop_cmd.is_tick)
        begin
            quiet_count_next = quiet_reload_reg;
            if (!answer_open_reg && !packet_open_reg)
            begin
                // The opening byte goes to index zero of its buffer.
                if (pop_cmd.opens_answer)
                begin
                    result_next.wr_en     = 1'b1;
                    result_next.wr_target = atrf_pkg::TGT_ANSWER;
                    result_next.wr_data   = pop_cmd.data;
                    write_index_next      = atrf_pkg::IDX_W'(1);
                    answer_open_next      = 1'b1;
                end
                else if (pop_cmd.opens_packet)
                begin
                    result_next.wr_en     = 1'b1;
                    result_next.wr_target = atrf_pkg::TGT_PACKET;
                    result_next.wr_data   = pop_cmd.data;
                    write_index_next      = atrf_pkg::IDX_W'(1);
                    packet_open_next      = 1'b1;
                end
            end
            else if (answer_open_reg)
            begin
                if (pop_cmd.is_newline)
                begin
                    answer_line_end_next = 1'b1;
                end
                result_next.wr_en     = 1'b1;
                result_next.wr_target = atrf_pkg::TGT_ANSWER;
                result_next.wr_addr   = write_index_reg;
                result_next.wr_data   = pop_cmd.data;
                if (write_index_reg < atrf_pkg::ANS_BUF_SIZE)
                begin
                    write_index_next = write_index_reg + 1'b1;
                end
                else
                begin
                    write_index_next            = '0;
                    result_next.answer_overflow = 1'b1;
                end
            end
            else
            begin
                if (pop_cmd.is_newline)
                begin
                    packet_line_end_next = 1'b1;
                end
                result_next.wr_en     = 1'b1;
                result_next.wr_target = atrf_pkg::TGT_PACKET;
                result_next.wr_addr   = write_index_reg;
                result_next.wr_data   = pop_cmd.data;
                if (write_index_reg < atrf_pkg::PKT_BUF_SIZE)
                begin
                    write_index_next = write_index_reg + 1'b1;
                end
                else
                begin
                    write_index_next            = '0;
                    result_next.packet_overflow = 1'b1;
                end
            end
        end
        else
        begin
            quiet_count_next = quiet_dec;
            if (quiet_dec == '0)
            begin
                if (answer_open_reg && answer_line_end_reg)
                begin
                    answer_open_next         = 1'b0;
                    answer_line_end_next     = 1'b0;
                    result_next.answer_ready = 1'b1;
                end
                if (packet_open_reg && packet_line_end_reg)
                begin
                    packet_open_next         = 1'b0;
                    packet_line_end_next     = 1'b0;
                    result_next.packet_ready = 1'b1;
                end
            end
        end

        if (step)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quiet_reload_reg    <= atrf_pkg::QUIET_RELOAD_RESET;
            quiet_count_reg     <= '0;
            write_index_reg     <= '0;
            answer_open_reg     <= 1'b0;
            answer_line_end_reg <= 1'b0;
            packet_open_reg     <= 1'b0;
            packet_line_end_reg <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            quiet_reload_reg <= quiet_reload_next;
            out_valid_reg    <= out_valid_next;
            if (step)
            begin
                quiet_count_reg     <= quiet_count_next;
                write_index_reg     <= write_index_next;
                answer_open_reg     <= answer_open_next;
                answer_line_end_reg <= answer_line_end_next;
                packet_open_reg     <= packet_open_next;
                packet_line_end_reg <= packet_line_end_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            result_reg <= result_next;
        end
    end

    `ATRF_ASSERT_NOW(a_one_frame_open, clk, rst_n, answer_open_reg, !packet_open_reg,
                     "both frames open")
    `ATRF_ASSERT_NOW(a_line_end_needs_open, clk, rst_n,
                     answer_line_end_reg || packet_line_end_reg,
                     answer_open_reg || packet_open_reg, "line end without open frame")
    `ATRF_ASSERT_NOW(a_index_in_range, clk, rst_n, 1'b1,
                     write_index_reg <= atrf_pkg::ANS_BUF_SIZE, "write index beyond buffer end")
    `ATRF_ASSERT_NOW(a_write_not_ready, clk, rst_n, out_valid_reg && result_reg.wr_en,
                     !result_reg.answer_ready && !result_reg.packet_ready,
                     "write and frame close in one item")
    `ATRF_ASSERT_NEXT(a_close_clears, clk, rst_n, step && result_next.answer_ready,
                      !answer_open_reg && !answer_line_end_reg,
                      "answer frame still open after close")

endmodule

// ----- hw/rtl/at_response_rx_framer_core.sv -----
// An accepted item is stored in the queue, then its result is registered in the back end.
// The back end takes one item per cycle unless a low m_axis_tready holds a waiting result.
// A two-entry queue parts input and output, so input is taken while a result waits.
// Reset (rst_n, asynchronous, active low) closes both frames, clears the index, the quiet
// counter and the queue, and sets quiet_reload to 5. Configuration is always ready.
module at_response_rx_framer_core
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [atrf_pkg::QUIET_W-1:0]   cfg_data,      // [15:0] quiet_reload
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [atrf_pkg::BYTE_W-1:0]    s_axis_tdata,  // [7:0] rx_byte
    input  logic                           s_axis_tuser,  // [0] action
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [0] wr_en, [9:1] wr_addr, [17:10] wr_data, [18] answer_ready,
    // [19] packet_ready, [20] answer_overflow, [21] packet_overflow, [23:22] zero
    output logic [23:0]                    m_axis_tdata,
    output logic                           m_axis_tuser   // [0] wr_target
);

    logic              push_valid;
    logic              push_ready;
    atrf_pkg::cmd_t    push_cmd;
    logic              pop_valid;
    logic              pop_ready;
    atrf_pkg::cmd_t    pop_cmd;
    atrf_pkg::result_t result;

    atrf_front u_front
    (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_cmd      (push_cmd)
    );

    atrf_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    atrf_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (result)
    );

    assign m_axis_tdata = {2'b00,
                           result.packet_overflow,
                           result.answer_overflow,
                           result.packet_ready,
                           result.answer_ready,
                           result.wr_data,
                           result.wr_addr,
                           result.wr_en};
    assign m_axis_tuser = result.wr_target;

endmodule
